/* src/fac_pkg.sv */
// Shared types and constants for the frustum box cull unit.
// Used by fac_plane_cell and frustum_aabb_cull_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fac_pkg;

  // Number of plane cells in the chain, and how many of them have a register.
  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned PLANE_REGS = 6;

  // Field widths.
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned PLANE_W  = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W   = 2 * COORD_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned D_SHIFT  = 13;

  // Pipeline capacity: two stages per cell plus the output register.
  localparam int unsigned PIPE_CAP = 2 * NUM_PLANES + 1;
  localparam int unsigned CNT_W    = $clog2(PIPE_CAP + 1);

  // One box as it travels down the chain.
  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

  // Word handed from one cell to the next: the box and the running reject flag.
  typedef struct packed {
    box_t box;
    logic reject;
  } link_t;

endpackage

`default_nettype wire

/* src/frustum_aabb_cull_unit.sv */
// Frustum box cull unit: a chain of plane cells, one per plane, then an output register.
// Throughput: one box per cycle unless out_stall_i holds the chain; each cell is a two-stage
// slice (products, then sum).
// Reset: asynchronous, active low; clears all pipeline valids and zeroes every plane,
// so after reset every box is reported visible. Depends on fac_pkg and fac_plane_cell.
`timescale 1ns / 1ps
`default_nettype none

module frustum_aabb_cull_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [fac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [fac_pkg::PLANE_W-1:0]   cfg_data_i,
  // Box input channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [fac_pkg::COORD_W-1:0] min_x_i,
  input  wire logic signed [fac_pkg::COORD_W-1:0] min_y_i,
  input  wire logic signed [fac_pkg::COORD_W-1:0] min_z_i,
  input  wire logic signed [fac_pkg::COORD_W-1:0] max_x_i,
  input  wire logic signed [fac_pkg::COORD_W-1:0] max_y_i,
  input  wire logic signed [fac_pkg::COORD_W-1:0] max_z_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               visible_o
);

  localparam int unsigned NP = fac_pkg::NUM_PLANES;

  // Plane registers are always writable.
  assign cfg_ready_o = 1'b1;

  // Links between cells; index 0 is the input side.
  logic           link_valid [NP+1];
  logic           link_ready [NP+1];
  fac_pkg::link_t link_word  [NP+1];

  assign link_valid[0]            = in_valid_i;
  assign link_word[0].box.min_x   = min_x_i;
  assign link_word[0].box.min_y   = min_y_i;
  assign link_word[0].box.min_z   = min_z_i;
  assign link_word[0].box.max_x   = max_x_i;
  assign link_word[0].box.max_y   = max_y_i;
  assign link_word[0].box.max_z   = max_z_i;
  assign link_word[0].reject      = 1'b0;
  assign in_stall_o               = !link_ready[0];

  // The cell chain, with the register write decoded per cell.
  for (genvar g = 0; g < NP; g++) begin : g_cell
    logic plane_we;
    if (g < fac_pkg::PLANE_REGS) begin : g_we
      assign plane_we = cfg_valid_i &&
                        (cfg_index_i == fac_pkg::CFG_IDX_W'(g));
    end else begin : g_no_we
      assign plane_we = 1'b0;
    end

    fac_plane_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .plane_we_i   (plane_we),
      .plane_data_i (cfg_data_i),
      .up_valid_i   (link_valid[g]),
      .up_link_i    (link_word[g]),
      .up_ready_o   (link_ready[g]),
      .dn_valid_o   (link_valid[g+1]),
      .dn_link_o    (link_word[g+1]),
      .dn_ready_i   (link_ready[g+1])
    );
  end

  // Output register decouples the chain from the result consumer.
  logic out_valid_q, visible_q;

  assign link_ready[NP] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (link_ready[NP]) begin
      out_valid_q <= link_valid[NP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_ready[NP] && link_valid[NP]) begin
      visible_q <= !link_word[NP].reject;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = visible_q;

  // Count of words in flight, for the checks below.
  logic                      in_take, out_take;
  logic [fac_pkg::CNT_W-1:0] flight_q;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else if (in_take && !out_take) begin
      flight_q <= flight_q + fac_pkg::CNT_W'(1);
    end else if (out_take && !in_take) begin
      flight_q <= flight_q - fac_pkg::CNT_W'(1);
    end
  end

  // An empty output register lets the whole chain move, so input is never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled while output register is empty");

  // The chain never holds more words than it has stages.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q <= fac_pkg::CNT_W'(fac_pkg::PIPE_CAP))
    else $error("more words in flight than pipeline stages");

  // A result is only offered when some box is still in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flight_q == '0) |-> !out_valid_q)
    else $error("result offered with no box in flight");

  // A full chain with a stalled output must hold off the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flight_q == fac_pkg::CNT_W'(fac_pkg::PIPE_CAP)) && out_stall_i |-> in_stall_o)
    else $error("input accepted into a full chain");

endmodule

`default_nettype wire

/* src/fac_plane_cell.sv */
// One cell of the cull chain: holds one plane and tests each passing box.
// Depends on fac_pkg for the link word and widths.
`timescale 1ns / 1ps
`default_nettype none

module fac_plane_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        plane_we_i,
  input  wire logic [fac_pkg::PLANE_W-1:0] plane_data_i,
  input  wire logic                        up_valid_i,
  input  wire fac_pkg::link_t              up_link_i,
  output logic                             up_ready_o,
  output logic                             dn_valid_o,
  output fac_pkg::link_t                   dn_link_o,
  input  wire logic                        dn_ready_i
);

  localparam int unsigned CW = fac_pkg::COORD_W;
  localparam int unsigned PW = fac_pkg::PROD_W;
  localparam int unsigned SW = fac_pkg::SUM_W;

  // Plane register: a, b, c in Q2.13 and d as an integer, low to high.
  logic [fac_pkg::PLANE_W-1:0] plane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (plane_we_i) begin
      plane_q <= plane_data_i;
    end
  end

  logic signed [CW-1:0] coef_a, coef_b, coef_c, coef_d;
  assign coef_a = plane_q[CW-1:0];
  assign coef_b = plane_q[2*CW-1:CW];
  assign coef_c = plane_q[3*CW-1:2*CW];
  assign coef_d = plane_q[4*CW-1:3*CW];

  // Pick the coordinate that maximizes coef * coord on one axis.
  function automatic logic signed [CW-1:0] pick_far(
    input logic signed [CW-1:0] coef,
    input logic signed [CW-1:0] lo,
    input logic signed [CW-1:0] hi
  );
    logic lo_bigger;
    lo_bigger = (lo > hi);
    if (coef[CW-1]) begin
      pick_far = lo_bigger ? hi : lo;
    end else begin
      pick_far = lo_bigger ? lo : hi;
    end
  endfunction

  // Stage A: choose the farthest corner and form the three products.
  logic signed [CW-1:0] sel_x, sel_y, sel_z;
  logic signed [PW-1:0] prod_x_d, prod_y_d, prod_z_d;

  always_comb begin
    sel_x    = pick_far(coef_a, up_link_i.box.min_x, up_link_i.box.max_x);
    sel_y    = pick_far(coef_b, up_link_i.box.min_y, up_link_i.box.max_y);
    sel_z    = pick_far(coef_c, up_link_i.box.min_z, up_link_i.box.max_z);
    prod_x_d = PW'(coef_a) * PW'(sel_x);
    prod_y_d = PW'(coef_b) * PW'(sel_y);
    prod_z_d = PW'(coef_c) * PW'(sel_z);
  end

  logic                 valid_a_q, valid_b_q;
  logic                 ready_a, ready_b;
  fac_pkg::link_t       link_a_q, link_b_q;
  logic signed [PW-1:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [CW-1:0] d_q;

  // A stage takes a new word when it is empty or its word moves on.
  assign ready_b    = !valid_b_q || dn_ready_i;
  assign ready_a    = !valid_a_q || ready_b;
  assign up_ready_o = ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_q <= up_valid_i;
      end
      if (ready_b) begin
        valid_b_q <= valid_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && up_valid_i) begin
      link_a_q <= up_link_i;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
      prod_z_q <= prod_z_d;
      d_q      <= coef_d;
    end
  end

  // Stage B: the distance at the farthest corner; negative means the box is behind.
  logic signed [SW-1:0] dist_max;
  logic                 behind;

  always_comb begin
    dist_max = SW'(prod_x_q) + SW'(prod_y_q) + SW'(prod_z_q)
             + (SW'(d_q) <<< fac_pkg::D_SHIFT);
    behind   = dist_max[SW-1];
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && valid_a_q) begin
      link_b_q.box    <= link_a_q.box;
      link_b_q.reject <= link_a_q.reject | behind;
    end
  end

  assign dn_valid_o = valid_b_q;
  assign dn_link_o  = link_b_q;

endmodule

`default_nettype wire
